// ----- rtl/biquad_cascade_graphic_eq_top_macros.svh -----
// Assertion macros shared by the checker
`ifndef BIQUAD_CASCADE_GRAPHIC_EQ_TOP_MACROS_SVH
`define BIQUAD_CASCADE_GRAPHIC_EQ_TOP_MACROS_SVH

// Implication checked every clock outside reset
`define BQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");

// Next-cycle implication outside reset
`define BQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

// ----- rtl/bqeq_pkg.sv -----
package bqeq_pkg;
  localparam int BANDS = 16;
  localparam int CHANNELS = 2;
  localparam int BAND_W = 4;
  localparam int CH_W = 1;
  localparam int SAMPLE_W = 24;
  localparam int SIG_W = 32;
  localparam int COEF_W = 32;
  localparam int DLY_W = 48;
  localparam int PROD_W = 64;
  localparam int WORDS_PER_BAND = 5;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEFF  = 1'b1;

  localparam logic [2:0] CI_B0 = 3'd0;
  localparam logic [2:0] CI_B1 = 3'd1;
  localparam logic [2:0] CI_B2 = 3'd2;
  localparam logic [2:0] CI_A1 = 3'd3;
  localparam logic [2:0] CI_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEFF_ONE = 32'sh1000_0000;

  // Token travelling from one cell to the next
  typedef struct packed {
    logic                        valid;
    logic [CH_W-1:0]             ch;
    logic signed [SIG_W-1:0]     x;
    logic                        clip;
  } bq_tok_t;

  // Coefficient write broadcast to all cells
  typedef struct packed {
    logic                        en;
    logic [BAND_W-1:0]           band;
    logic [2:0]                  idx;
    logic signed [COEF_W-1:0]    value;
  } bq_cwr_t;

  // Q13.51 product rounded to Q17.31 (round half up)
  function automatic logic signed [DLY_W+1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    begin
      t = (p + 64'sd524288) >>> 20;
      rnd_prod = t[DLY_W+1:0];
    end
  endfunction

  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [DLY_W+1:0] v);
    logic signed [DLY_W+1:0] hi, lo;
    begin
      hi = {3'b000, {(DLY_W-1){1'b1}}};
      lo = {3'b111, {(DLY_W-1){1'b0}}};
      if (v > hi) sat_dly = hi[DLY_W-1:0];
      else if (v < lo) sat_dly = lo[DLY_W-1:0];
      else sat_dly = v[DLY_W-1:0];
    end
  endfunction
endpackage

// ----- rtl/bqeq_cell.sv -----
// One biquad section; a state sequence over a single multiplier
module bqeq_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bqeq_pkg::BAND_W-1:0]   band_id,
  input  bqeq_pkg::bq_cwr_t             cwr,
  input  bqeq_pkg::bq_tok_t             tok_in,
  output bqeq_pkg::bq_tok_t             tok_out
);
  import bqeq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_Y, S_D1, S_D2, S_D2B, S_OUT} st_t;

  logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
  logic signed [DLY_W-1:0]  d1 [CHANNELS];
  logic signed [DLY_W-1:0]  d2 [CHANNELS];
  st_t                      st;
  logic [CH_W-1:0]          ch;
  logic signed [SIG_W-1:0]  x, y;
  logic                     clip;
  logic signed [PROD_W-1:0] prod;
  logic signed [DLY_W+1:0]  pa;
  logic signed [SIG_W-1:0]  m_sig;
  logic signed [COEF_W-1:0] m_coef;
  logic signed [DLY_W+1:0]  acc;
  logic signed [DLY_W+1:0]  yr;
  logic signed [DLY_W+1:0]  yv;

  // Multiplier operand select; idle starts b0*x on the incoming word
  always_comb begin
    m_sig = x;
    m_coef = b0;
    case (st)
      S_IDLE: begin m_sig = tok_in.x; m_coef = b0; end
      S_Y:    begin m_sig = x; m_coef = b1; end
      S_D1:   begin m_sig = y; m_coef = a1; end
      S_D2:   begin m_sig = x; m_coef = b2; end
      S_D2B:  begin m_sig = y; m_coef = a2; end
      default: begin m_sig = x; m_coef = b0; end
    endcase
  end

  // Product register feeds accumulate next cycle
  assign pa = rnd_prod(prod);
  assign yr = (pa + $signed({{2{d1[ch][DLY_W-1]}}, d1[ch]}) + 50'sd128) >>> 8;

  // y saturate to 32 bits
  always_comb begin
    if (yr > 50'sh7FFF_FFFF) yv = 50'sh7FFF_FFFF;
    else if (yr < -50'sh8000_0000) yv = -50'sh8000_0000;
    else yv = yr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      tok_out.valid <= 1'b0;
      b0 <= COEFF_ONE; b1 <= '0; b2 <= '0; a1 <= '0; a2 <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        d1[i] <= '0;
        d2[i] <= '0;
      end
    end else begin
      tok_out.valid <= 1'b0;
      prod <= m_sig * m_coef;
      if (cwr.en && cwr.band == band_id) begin
        case (cwr.idx)
          CI_B0: b0 <= cwr.value;
          CI_B1: b1 <= cwr.value;
          CI_B2: b2 <= cwr.value;
          CI_A1: a1 <= cwr.value;
          CI_A2: a2 <= cwr.value;
          default: ;
        endcase
      end
      case (st)
        S_IDLE: begin
          if (tok_in.valid) begin
            ch <= tok_in.ch; x <= tok_in.x; clip <= tok_in.clip;
            st <= S_Y;
          end
        end
        S_Y: begin
          // prod holds b0*x
          y <= yv[SIG_W-1:0];
          if (yv != yr) clip <= 1'b1;
          st <= S_D1;
        end
        S_D1: begin
          acc <= $signed({{2{d2[ch][DLY_W-1]}}, d2[ch]}) + pa;  // b1*x
          st <= S_D2;
        end
        S_D2: begin
          d1[ch] <= sat_dly(acc + pa);  // a1*y
          st <= S_D2B;
        end
        S_D2B: begin
          acc <= pa;  // b2*x
          st <= S_OUT;
        end
        S_OUT: begin
          d2[ch] <= sat_dly(acc + pa);  // a2*y
          st <= S_IDLE;
          tok_out.valid <= 1'b1;
          tok_out.ch <= ch;
          tok_out.x <= y;
          tok_out.clip <= clip;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/biquad_cascade_graphic_eq_top.sv -----
// A sample passes the entry register tok[0], states S_IDLE through S_OUT of each band
// cell and the output register before out_valid rises; in bypass out_valid is registered from the sample.
// One sample at a time; next sample accepted the cycle after the output
// word is taken.
// Coefficient words give no result and leave the input free for the next word.
// Reset (rst, synchronous): bypass set, b0 = 1.0, other coefficients and delays zero.
module biquad_cascade_graphic_eq_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  command,
  input  logic                                  channel,
  input  logic signed [bqeq_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [bqeq_pkg::BAND_W-1:0]           band,
  input  logic [2:0]                            coeff_index,
  input  logic signed [bqeq_pkg::COEF_W-1:0]    coeff_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bqeq_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                  channel_out,
  output logic                                  saturated
);
  import bqeq_pkg::*;

  bq_tok_t tok [BANDS+1];
  bq_cwr_t cwr;
  logic    bypass;
  logic    busy;
  logic    acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign acc       = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) bypass <= 1'b1;
    else if (cfg_valid && cfg_ready) bypass <= cfg_data;
  end

  // Entry register, coefficient broadcast, busy flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
      cwr.en <= 1'b0;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tok[0].valid <= 1'b0;
      cwr.en <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
        busy <= 1'b0;
      end
      if (acc) begin
        if (command == CMD_COEFF) begin
          cwr.en <= (coeff_index <= CI_A2);
          cwr.band <= band; cwr.idx <= coeff_index; cwr.value <= coeff_value;
        end else begin
          busy <= 1'b1;
          if (bypass) begin
            out_valid <= 1'b1;
            sample_out <= sample_in;
            channel_out <= channel;
            saturated <= 1'b0;
          end else begin
            tok[0].valid <= 1'b1;
            tok[0].ch <= channel;
            tok[0].x <= SIG_W'(sample_in);
            tok[0].clip <= 1'b0;
          end
        end
      end
      // Final 24-bit saturation
      if (tok[BANDS].valid) begin
        out_valid <= 1'b1;
        channel_out <= tok[BANDS].ch;
        if (tok[BANDS].x > 32'sh7F_FFFF) begin
          sample_out <= 24'sh7F_FFFF; saturated <= 1'b1;
        end else if (tok[BANDS].x < -32'sh80_0000) begin
          sample_out <= 24'sh80_0000; saturated <= 1'b1;
        end else begin
          sample_out <= tok[BANDS].x[SAMPLE_W-1:0]; saturated <= tok[BANDS].clip;
        end
      end
    end
  end

  for (genvar g = 0; g < BANDS; g++) begin : g_cell
    bqeq_cell u_cell (
      .clk(clk), .rst(rst), .band_id(BAND_W'(g)), .cwr(cwr),
      .tok_in(tok[g]), .tok_out(tok[g+1])
    );
  end
endmodule

// ----- rtl/bqeq_checker.sv -----
`include "biquad_cascade_graphic_eq_top_macros.svh"
module bqeq_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic command,
  input logic out_valid,
  input logic out_stall,
  input logic [23:0] sample_out
);
  import bqeq_pkg::*;

  `BQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out))
  `BQ_ASSERT_IMP(a_stall_while_out, out_valid, in_stall)
  `BQ_ASSERT_NXT(a_sample_busy, in_valid && !in_stall && command == CMD_FILTER, in_stall)
endmodule

bind biquad_cascade_graphic_eq_top bqeq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .command(command),
  .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out)
);

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bqeq_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 120;

  // one expected output word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       ch;
    logic                       sat;
  } eq_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_FILTER;
  logic channel = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic [BAND_W-1:0] band = '0;
  logic [2:0] coeff_index = CI_B0;
  logic signed [COEF_W-1:0] coeff_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic channel_out;
  logic saturated;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  biquad_cascade_graphic_eq_top dut (.*);

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // equaliser model and queue of pending output words
  class eq_scoreboard;
    logic signed [COEF_W-1:0] coef [BANDS*WORDS_PER_BAND];
    logic signed [DLY_W-1:0]  dly [CHANNELS*BANDS*2];
    bit bypass;
    eq_word_t pending[$];

    function new();
      foreach (coef[i]) coef[i] = (i % WORDS_PER_BAND == 0) ? COEFF_ONE : '0;
      foreach (dly[i]) dly[i] = '0;
      bypass = 1'b1;
    endfunction

    // product rounded from Q13.51 to Q17.31
    function longint prod_q31(longint sig, longint c);
      longint p;
      p = sig * c + 64'sd524288;
      return p >>> 20;
    endfunction

    function longint clip_to(longint v, longint lo, longint hi, ref bit clip);
      if (v > hi) begin
        clip = 1;
        return hi;
      end
      if (v < lo) begin
        clip = 1;
        return lo;
      end
      return v;
    endfunction

    function void note_input(logic cmd, logic ch, logic signed [SAMPLE_W-1:0] s,
                             logic [BAND_W-1:0] b, logic [2:0] ci,
                             logic signed [COEF_W-1:0] cv);
      longint x, acc, y;
      longint dmax, dmin;
      bit clip, dummy;
      int base;
      eq_word_t w;
      dmax = 64'sh7FFF_FFFF_FFFF;
      dmin = -64'sh8000_0000_0000;
      if (cmd == CMD_COEFF) begin
        if (b < BANDS && ci <= CI_A2) coef[b*WORDS_PER_BAND + ci] = cv;
        return;
      end
      x = s;
      clip = 0;
      if (!bypass && ch < CHANNELS) begin
        for (int st = 0; st < BANDS; st++) begin
          base = (ch*BANDS + st)*2;
          acc = prod_q31(x, coef[st*5]) + longint'(dly[base]);
          y = clip_to((acc + 128) >>> 8, -64'sd2147483648, 64'sd2147483647, clip);
          dly[base] = clip_to(prod_q31(x, coef[st*5+1]) + prod_q31(y, coef[st*5+3])
                              + longint'(dly[base+1]), dmin, dmax, dummy);
          dly[base+1] = clip_to(prod_q31(x, coef[st*5+2]) + prod_q31(y, coef[st*5+4]),
                                dmin, dmax, dummy);
          x = y;
        end
        x = clip_to(x, -64'sd8388608, 64'sd8388607, clip);
      end
      w.smp = x[SAMPLE_W-1:0];
      w.ch = ch;
      w.sat = clip;
      pending.push_back(w);
    endfunction

    task check_output(logic signed [SAMPLE_W-1:0] s, logic ch, logic sat);
      eq_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %0d", s));
        return;
      end
      w = pending.pop_front();
      if (s !== w.smp) report($sformatf("sample_out %0d, want %0d", s, w.smp));
      if (ch !== w.ch) report($sformatf("channel_out %0b, want %0b", ch, w.ch));
      if (sat !== w.sat) report($sformatf("saturated %0b, want %0b", sat, w.sat));
    endtask
  endclass

  eq_scoreboard sb = new();

  // output side: random stall, check on accept
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_output(sample_out, channel_out, saturated);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays up after an accepted word until the sender idles or drains
  task automatic send_word(input logic cmd, input logic ch, input logic signed [23:0] s,
                           input logic [3:0] b, input logic [2:0] ci,
                           input logic signed [31:0] cv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    channel <= ch;
    sample_in <= s;
    band <= b;
    coeff_index <= ci;
    coeff_value <= cv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, ch, s, b, ci, cv);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bypass(input bit v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.bypass = v;
    cfg_valid <= 1'b0;
  endtask

  // gentle coefficient: b0 near 1, small others so the cascade mostly stays in range; wild gives random words
  task automatic load_band(input int b, input bit wild);
    logic signed [31:0] v;
    for (int ci = 0; ci <= 4; ci++) begin
      if (wild) v = $urandom();
      else if (ci == 0) v = 32'sh1000_0000 + $signed(32'($urandom_range(0, 2**22))) - 2**21;
      else v = $signed(32'($urandom_range(0, 2**22))) - 2**21;
      send_word(CMD_COEFF, 1'b0, 24'($urandom()), 4'(b), 3'(ci), v);
    end
  endtask

  task automatic random_sample();
    logic signed [23:0] s;
    case ($urandom_range(3))
      0: s = 24'sh7FFFFF;
      1: s = -24'sh800000;
      default: s = 24'($urandom());
    endcase
    send_word(CMD_FILTER, 1'($urandom()), s, 4'($urandom()), 3'($urandom()), $urandom());
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        // coefficient write, sometimes to an illegal index
        send_word(CMD_COEFF, 1'($urandom()), 24'($urandom()), 4'($urandom()),
                  3'($urandom_range(0, 7)), $urandom_range(0, 1) ? $urandom() :
                  $signed(32'($urandom_range(0, 2**22))) - 2**21);
      end else begin
        random_sample();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bypass at reset, extremes
    send_word(CMD_FILTER, 1'b0, 24'sh7FFFFF, '0, CI_B0, '0);
    send_word(CMD_FILTER, 1'b1, -24'sh800000, 4'hF, 3'd7, 32'hFFFF_FFFF);
    write_bypass(1'b0);
    // unity cascade
    send_word(CMD_FILTER, 1'b0, 24'sh7FFFFF, '0, CI_B0, '0);
    send_word(CMD_FILTER, 1'b1, -24'sh800000, '0, CI_B0, '0);
    send_word(CMD_FILTER, 1'b0, 24'sh000001, '0, CI_B0, '0);
    // ignored index, largest gain to force clipping
    send_word(CMD_COEFF, 1'b0, '0, 4'd3, 3'd5, 32'sh7FFF_FFFF);
    send_word(CMD_COEFF, 1'b0, '0, 4'd0, CI_B0, 32'sh7FFF_FFFF);
    send_word(CMD_COEFF, 1'b0, '0, 4'd1, CI_B0, 32'sh7FFF_FFFF);
    send_word(CMD_FILTER, 1'b0, 24'sh7FFFFF, '0, CI_B0, '0);
    send_word(CMD_FILTER, 1'b1, -24'sh800000, '0, CI_B0, '0);
    send_word(CMD_COEFF, 1'b0, '0, 4'd0, CI_B0, -32'sh8000_0000);
    send_word(CMD_COEFF, 1'b0, '0, 4'd15, CI_A1, -32'sh8000_0000);
    send_word(CMD_COEFF, 1'b0, '0, 4'd15, CI_A2, 32'sh7FFF_FFFF);
    send_word(CMD_COEFF, 1'b0, '0, 4'd15, CI_B1, 32'sh7FFF_FFFF);
    send_word(CMD_COEFF, 1'b0, '0, 4'd15, CI_B2, -32'sh8000_0000);
    send_word(CMD_FILTER, 1'b0, -24'sh800000, '0, CI_B0, '0);
    send_word(CMD_FILTER, 1'b0, 24'sh7FFFFF, '0, CI_B0, '0);
    send_word(CMD_FILTER, 1'b0, 24'sh000000, '0, CI_B0, '0);

    // random phases with sane coefficients
    for (int b = 0; b < BANDS; b++) load_band(b, 1'b0);
    random_run(150);
    send_idle_pct = 79;
    random_run(120);
    // sender pauses until all outputs are in
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 79;
    random_run(120);
    write_bypass(1'b1);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    random_run(100);
    write_bypass(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_run(120);
    // wild coefficients
    for (int b = 0; b < BANDS; b++) load_band(b, 1'b1);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    random_run(100);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
